@@ design/pvu_pkg.sv @@
// Shared types, constants and the arctangent table for the velocity-to-unicycle pipeline.
package pvu_pkg;

	localparam int XW = 34;
	localparam int IDXW = 4;
	localparam int VW = 16;
	localparam int LW = 15;
	localparam int VMAGW = 17;
	localparam int WMAGW = 29;
	localparam int PROD_W = XW + VW;
	localparam int SUM_W = PROD_W + 1;
	localparam int DIV2_QW = 16;
	localparam int DIV2_NW = WMAGW + DIV2_QW;
	localparam int ATAN_LEN = 24;

	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [XW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [XW-1:0] HALF_TURN = 34'sd2147483648;

	localparam logic [1:0] REG_MAX_LINEAR = 2'd0;
	localparam logic [1:0] REG_MAX_TURN = 2'd1;
	localparam logic [1:0] REG_OFFSET = 2'd2;

	localparam logic [LW-1:0] RST_MAX_LINEAR = 15'd4096;
	localparam logic [LW-1:0] RST_MAX_TURN = 15'd4096;
	localparam logic [LW-1:0] RST_OFFSET = 15'd410;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [XW-1:0] z;
		logic flip;
		logic [IDXW-1:0] idx;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
	} cord_t;

	typedef struct packed {
		logic [IDXW-1:0] idx;
		logic v_neg;
		logic [VMAGW-1:0] v_mag;
		logic w_neg;
	} tag1_t;

	typedef struct packed {
		logic [IDXW-1:0] idx;
		logic v_neg;
		logic [VMAGW-1:0] v_mag;
		logic w_neg;
		logic [WMAGW-1:0] w_mag;
		logic over;
		logic br_v;
	} tag2_t;

	function automatic logic [31:0] atan_val(input int i);
		logic [31:0] r;
		unique case (i)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

@@ design/planar_velocity_to_unicycle_cmd.sv @@
// Top level: CORDIC rotation, offset division and proportional limit scaling, fully pipelined.
//
//  channel   handshake              payload
//  input     start / busy           robot_index, heading, want_vx, want_vy
//  result    done (one-cycle word)  target_robot, linear_speed, turn_rate, was_scaled
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is taken every cycle; busy is always low.
// Pipeline stages, in order: fold, CORDIC cells, multiply, sum, round,
// 29 turn-rate divider cells, limit products, select, 16 scaling divider cells, output.
// Reset clears valid bits and loads the register defaults; the result side cannot stall.
module planar_velocity_to_unicycle_cmd #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         robot_index,
	input  logic signed [15:0] heading,
	input  logic signed [15:0] want_vx,
	input  logic signed [15:0] want_vy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	output logic               done,
	output logic [3:0]         target_robot,
	output logic signed [15:0] linear_speed,
	output logic signed [15:0] turn_rate,
	output logic               was_scaled
);
	import pvu_pkg::*;

	localparam int NS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
	localparam int T1W = $bits(tag1_t);
	localparam int T2W = $bits(tag2_t);

	logic [LW-1:0] max_lin_q;
	logic [LW-1:0] max_turn_q;
	logic [LW-1:0] offset_q;
	logic [LW-1:0] mv;
	logic [LW-1:0] mw;
	logic [LW-1:0] off_eff;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lin_q <= RST_MAX_LINEAR;
			max_turn_q <= RST_MAX_TURN;
			offset_q <= RST_OFFSET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_LINEAR: max_lin_q <= cfg_data;
				REG_MAX_TURN: max_turn_q <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign mv = (max_lin_q == '0) ? LW'(1) : max_lin_q;
	assign mw = (max_turn_q == '0) ? LW'(1) : max_turn_q;
	assign off_eff = (offset_q == '0) ? LW'(1) : offset_q;

	// angle fold
	logic signed [XW-1:0] z0;
	cord_t fold;
	logic vld_s1;
	cord_t fold_s1;

	always_comb begin
		z0 = {{2{heading[15]}}, heading, 16'd0};
		fold.x = CORDIC_GAIN;
		fold.y = '0;
		fold.flip = 1'b0;
		fold.z = z0;
		fold.idx = robot_index;
		fold.vx = want_vx;
		fold.vy = want_vy;
		if (z0 > QUARTER_TURN) begin
			fold.z = z0 - HALF_TURN;
			fold.flip = 1'b1;
		end else if (z0 < -QUARTER_TURN) begin
			fold.z = z0 + HALF_TURN;
			fold.flip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		fold_s1 <= fold;
	end

	// CORDIC chain
	cord_t cw [0:NS];
	logic cv [0:NS];

	assign cw[0] = fold_s1;
	assign cv[0] = vld_s1;

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		pvu_cordic_cell #(.IDX(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(cv[i]),
			.in_word(cw[i]),
			.out_valid(cv[i+1]),
			.out_word(cw[i+1])
		);
	end

	// products
	logic signed [XW-1:0] cos_v;
	logic signed [XW-1:0] sin_v;
	logic signed [PROD_W-1:0] p_cvx;
	logic signed [PROD_W-1:0] p_svy;
	logic signed [PROD_W-1:0] p_cvy;
	logic signed [PROD_W-1:0] p_svx;

	assign cos_v = cw[NS].flip ? -cw[NS].x : cw[NS].x;
	assign sin_v = cw[NS].flip ? -cw[NS].y : cw[NS].y;
	assign p_cvx = cos_v * cw[NS].vx;
	assign p_svy = sin_v * cw[NS].vy;
	assign p_cvy = cos_v * cw[NS].vy;
	assign p_svx = sin_v * cw[NS].vx;

	logic vld_s2;
	logic [IDXW-1:0] idx_s2;
	logic signed [PROD_W-1:0] cvx_s2;
	logic signed [PROD_W-1:0] svy_s2;
	logic signed [PROD_W-1:0] cvy_s2;
	logic signed [PROD_W-1:0] svx_s2;

	logic vld_s3;
	logic [IDXW-1:0] idx_s3;
	logic signed [SUM_W-1:0] nv_s3;
	logic signed [SUM_W-1:0] nw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= cv[NS];
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= cw[NS].idx;
		cvx_s2 <= p_cvx;
		svy_s2 <= p_svy;
		cvy_s2 <= p_cvy;
		svx_s2 <= p_svx;
		idx_s3 <= idx_s2;
		nv_s3 <= SUM_W'(cvx_s2) + SUM_W'(svy_s2);
		nw_s3 <= SUM_W'(cvy_s2) - SUM_W'(svx_s2);
	end

	// rounding of linear speed, prescale of turn-rate dividend
	logic [SUM_W-1:0] anv;
	logic [SUM_W-1:0] anw;
	logic [SUM_W-1:0] v_rnd;
	logic [SUM_W-1:0] w_pre;
	logic [VMAGW-1:0] v_mag4;
	tag1_t t1;

	always_comb begin
		anv = nv_s3[SUM_W-1] ? SUM_W'(-nv_s3) : SUM_W'(nv_s3);
		anw = nw_s3[SUM_W-1] ? SUM_W'(-nw_s3) : SUM_W'(nw_s3);
		v_rnd = anv + (SUM_W'(1) << 29);
		w_pre = anw + (SUM_W'(off_eff) << 17);
		v_mag4 = v_rnd[30 +: VMAGW];
		t1.idx = idx_s3;
		t1.v_mag = v_mag4;
		t1.v_neg = nv_s3[SUM_W-1] && (v_mag4 != '0);
		t1.w_neg = nw_s3[SUM_W-1];
	end

	logic vld_s4;
	logic [WMAGW-1:0] wdd_s4;
	logic [LW-1:0] off_s4;
	tag1_t t1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		wdd_s4 <= w_pre[18 +: WMAGW];
		off_s4 <= off_eff;
		t1_s4 <= t1;
	end

	// turn-rate divider chain
	logic d1v [0:WMAGW];
	logic [LW-1:0] d1r [0:WMAGW];
	logic [WMAGW-1:0] d1l [0:WMAGW];
	logic [LW-1:0] d1d [0:WMAGW];
	logic [T1W-1:0] d1t [0:WMAGW];

	assign d1v[0] = vld_s4;
	assign d1r[0] = '0;
	assign d1l[0] = wdd_s4;
	assign d1d[0] = off_s4;
	assign d1t[0] = t1_s4;

	for (genvar i = 0; i < WMAGW; i++) begin : g_div1
		pvu_div_cell #(.RW(LW), .DW(WMAGW), .TW(T1W)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(d1v[i]),
			.in_rem(d1r[i]),
			.in_lo(d1l[i]),
			.in_div(d1d[i]),
			.in_tag(d1t[i]),
			.out_valid(d1v[i+1]),
			.out_rem(d1r[i+1]),
			.out_lo(d1l[i+1]),
			.out_div(d1d[i+1]),
			.out_tag(d1t[i+1])
		);
	end

	// limit check and cross products
	tag1_t t1_end;
	logic [WMAGW-1:0] aw;
	logic vld_s5;
	tag2_t t2_s5;
	logic [VMAGW+LW-1:0] pa_s5;
	logic [WMAGW+LW-1:0] pb_s5;

	assign t1_end = tag1_t'(d1t[WMAGW]);
	assign aw = d1l[WMAGW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= d1v[WMAGW];
		end
	end

	always_ff @(posedge clk) begin
		t2_s5.idx <= t1_end.idx;
		t2_s5.v_neg <= t1_end.v_neg;
		t2_s5.v_mag <= t1_end.v_mag;
		t2_s5.w_neg <= t1_end.w_neg && (aw != '0);
		t2_s5.w_mag <= aw;
		t2_s5.over <= (t1_end.v_mag > VMAGW'(mv)) || (aw > WMAGW'(mw));
		t2_s5.br_v <= 1'b0;
		pa_s5 <= t1_end.v_mag * mw;
		pb_s5 <= aw * mv;
	end

	// branch select and scaling dividend
	logic br;
	logic [WMAGW+LW-1:0] num;
	logic [WMAGW-1:0] den;
	logic [DIV2_NW-1:0] nsum;
	tag2_t t2;

	always_comb begin
		br = ((WMAGW+LW)'(pa_s5) > pb_s5);
		num = br ? pb_s5 : (WMAGW+LW)'(pa_s5);
		den = br ? WMAGW'(t2_s5.v_mag) : t2_s5.w_mag;
		nsum = DIV2_NW'(num) + DIV2_NW'(den >> 1);
		t2 = t2_s5;
		t2.br_v = br;
	end

	logic vld_s6;
	logic [WMAGW-1:0] rem_s6;
	logic [DIV2_QW-1:0] lo_s6;
	logic [WMAGW-1:0] den_s6;
	tag2_t t2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		rem_s6 <= nsum[DIV2_QW +: WMAGW];
		lo_s6 <= nsum[DIV2_QW-1:0];
		den_s6 <= den;
		t2_s6 <= t2;
	end

	// scaling divider chain
	logic d2v [0:DIV2_QW];
	logic [WMAGW-1:0] d2r [0:DIV2_QW];
	logic [DIV2_QW-1:0] d2l [0:DIV2_QW];
	logic [WMAGW-1:0] d2d [0:DIV2_QW];
	logic [T2W-1:0] d2t [0:DIV2_QW];

	assign d2v[0] = vld_s6;
	assign d2r[0] = rem_s6;
	assign d2l[0] = lo_s6;
	assign d2d[0] = den_s6;
	assign d2t[0] = t2_s6;

	for (genvar i = 0; i < DIV2_QW; i++) begin : g_div2
		pvu_div_cell #(.RW(WMAGW), .DW(DIV2_QW), .TW(T2W)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(d2v[i]),
			.in_rem(d2r[i]),
			.in_lo(d2l[i]),
			.in_div(d2d[i]),
			.in_tag(d2t[i]),
			.out_valid(d2v[i+1]),
			.out_rem(d2r[i+1]),
			.out_lo(d2l[i+1]),
			.out_div(d2d[i+1]),
			.out_tag(d2t[i+1])
		);
	end

	// result assembly
	tag2_t tf;
	logic [VW-1:0] q;
	logic [VW-1:0] v_abs;
	logic [VW-1:0] w_abs;
	logic v_sgn;
	logic w_sgn;
	logic done_q;
	logic [IDXW-1:0] robot_q;
	logic [VW-1:0] lin_q;
	logic [VW-1:0] turn_q;
	logic scaled_q;

	always_comb begin
		tf = tag2_t'(d2t[DIV2_QW]);
		q = d2l[DIV2_QW];
		v_sgn = tf.v_neg;
		w_sgn = tf.w_neg;
		if (!tf.over) begin
			v_abs = VW'(tf.v_mag);
			w_abs = VW'(tf.w_mag);
		end else if (tf.br_v) begin
			v_abs = VW'(mv);
			w_abs = q;
		end else begin
			v_abs = q;
			w_abs = VW'(mw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d2v[DIV2_QW];
		end
	end

	always_ff @(posedge clk) begin
		robot_q <= tf.idx;
		lin_q <= v_sgn ? -v_abs : v_abs;
		turn_q <= w_sgn ? -w_abs : w_abs;
		scaled_q <= tf.over;
	end

	assign done = done_q;
	assign target_robot = robot_q;
	assign linear_speed = lin_q;
	assign turn_rate = turn_q;
	assign was_scaled = scaled_q;

endmodule

@@ design/pvu_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation with its pipeline register.
module pvu_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  pvu_pkg::cord_t in_word,
	output logic           out_valid,
	output pvu_pkg::cord_t out_word
);
	import pvu_pkg::*;

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [XW-1:0] ang;
	cord_t nxt;
	logic valid_q;
	cord_t word_q;

	always_comb begin
		dx = in_word.y >>> IDX;
		dy = in_word.x >>> IDX;
		ang = XW'(atan_val(IDX));
		nxt = in_word;
		if (!in_word.z[XW-1]) begin
			nxt.x = in_word.x - dx;
			nxt.y = in_word.y + dy;
			nxt.z = in_word.z - ang;
		end else begin
			nxt.x = in_word.x + dx;
			nxt.y = in_word.y - dy;
			nxt.z = in_word.z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_word = word_q;

endmodule

@@ design/pvu_div_cell.sv @@
// One restoring-division step: brings down a dividend bit, shifts in a quotient bit.
module pvu_div_cell #(
	parameter int RW = 15,
	parameter int DW = 29,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [RW-1:0] in_rem,
	input  logic [DW-1:0] in_lo,
	input  logic [RW-1:0] in_div,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [RW-1:0] out_rem,
	output logic [DW-1:0] out_lo,
	output logic [RW-1:0] out_div,
	output logic [TW-1:0] out_tag
);
	logic [RW:0] t;
	logic [RW:0] diff;
	logic ge;
	logic valid_q;
	logic [RW-1:0] rem_q;
	logic [DW-1:0] lo_q;
	logic [RW-1:0] div_q;
	logic [TW-1:0] tag_q;

	always_comb begin
		t = {in_rem, in_lo[DW-1]};
		diff = t - {1'b0, in_div};
		ge = (t >= {1'b0, in_div});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[RW-1:0] : t[RW-1:0];
		lo_q <= {in_lo[DW-2:0], ge};
		div_q <= in_div;
		tag_q <= in_tag;
	end

	assign out_valid = valid_q;
	assign out_rem = rem_q;
	assign out_lo = lo_q;
	assign out_div = div_q;
	assign out_tag = tag_q;

endmodule

@@ tb/tb_top.sv @@
// Testbench for planar_velocity_to_unicycle_cmd: a rotation and limit-scaling predictor checks every output word.
module tb_top;
	import pvu_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 52;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [3:0] robot;
		logic signed [15:0] speed;
		logic signed [15:0] rate;
		logic scaled;
	} unicycle_cmd_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [3:0] robot_index;
	logic signed [15:0] heading;
	logic signed [15:0] want_vx;
	logic signed [15:0] want_vy;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [14:0] cfg_data;
	logic done;
	logic [3:0] target_robot;
	logic signed [15:0] linear_speed;
	logic signed [15:0] turn_rate;
	logic was_scaled;

	int mismatches = 0;
	int idle_cycles = 0;
	bit no_gaps = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-(v + 1)) >>> s) + 1);
	endfunction

	function automatic longint round_div(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	class cmd_scoreboard;
		logic [14:0] speed_limit = RST_MAX_LINEAR;
		logic [14:0] rate_limit = RST_MAX_TURN;
		logic [14:0] offset = RST_OFFSET;
		unicycle_cmd_t pending[$];

		function void set_reg(logic [1:0] idx, logic [14:0] val);
			case (idx)
				REG_MAX_LINEAR: speed_limit = val;
				REG_MAX_TURN: rate_limit = val;
				REG_OFFSET: offset = val;
				default: ;
			endcase
		endfunction

		function void note_command(logic [3:0] robot, logic signed [15:0] head,
				logic signed [15:0] vx, logic signed [15:0] vy);
			longint z, x, y, dx, dy, c, s, v, w, av, aw, off, mv, mw;
			bit flip;
			unicycle_cmd_t e;
			z = longint'(head) * 65536;
			x = CORDIC_GAIN;
			y = 0;
			flip = 0;
			if (z > QUARTER_TURN) begin
				z -= HALF_TURN;
				flip = 1;
			end else if (z < -QUARTER_TURN) begin
				z += HALF_TURN;
				flip = 1;
			end
			for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
				dx = floor_shift(y, i);
				dy = floor_shift(x, i);
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(atan_val(i));
				end else begin
					x += dx;
					y -= dy;
					z += longint'(atan_val(i));
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
			off = offset ? offset : 1;
			mv = speed_limit ? speed_limit : 1;
			mw = rate_limit ? rate_limit : 1;
			v = round_div(c * vx + s * vy, longint'(1) << 30);
			w = round_div(c * vy - s * vx, off << 18);
			av = v < 0 ? -v : v;
			aw = w < 0 ? -w : w;
			e.scaled = 0;
			if (av > mv || aw > mw) begin
				e.scaled = 1;
				if (av * mw > aw * mv) begin
					w = round_div(w * mv, av);
					v = v < 0 ? -mv : mv;
				end else begin
					v = round_div(v * mw, aw);
					w = w < 0 ? -mw : mw;
				end
			end
			e.robot = robot;
			e.speed = v[15:0];
			e.rate = w[15:0];
			pending.push_back(e);
		endfunction

		task check_word(logic [3:0] robot, logic signed [15:0] speed,
				logic signed [15:0] rate, logic scaled);
			unicycle_cmd_t e;
			if (pending.size() == 0) begin
				report("unexpected word", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (robot !== e.robot)
				report("target_robot", robot, e.robot);
			if (speed !== e.speed)
				report("linear_speed", speed, e.speed);
			if (rate !== e.rate)
				report("turn_rate", rate, e.rate);
			if (scaled !== e.scaled)
				report("was_scaled", scaled, e.scaled);
		endtask
	endclass

	cmd_scoreboard sb = new();

	planar_velocity_to_unicycle_cmd #(.CORDIC_STAGES(STAGES)) uut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_word(target_robot, linear_speed, turn_rate, was_scaled);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic random_gap();
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic send_command(logic [3:0] r, logic [15:0] h, logic [15:0] vx,
			logic [15:0] vy);
		cfg_valid <= 1'b0;
		robot_index <= r;
		heading <= h;
		want_vx <= vx;
		want_vy <= vy;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(r, h, vx, vy);
		@(negedge clk);
		random_gap();
	endtask

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		cfg_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_velocity();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 4096)) - 2048);
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	task automatic random_commands(int n);
		for (int k = 0; k < n; k++)
			send_command(4'($urandom), 16'($urandom), pick_velocity(), pick_velocity());
	endtask

	initial begin
		logic [15:0] edges[6];
		edges = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h0001};
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_LINEAR;
		cfg_data = '0;
		robot_index = '0;
		heading = '0;
		want_vx = '0;
		want_vy = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 6; i++)
			send_command(4'(i * 3), edges[i], edges[(i + 1) % 6], edges[(i + 2) % 6]);
		send_command(4'hf, 16'h2000, 16'h0000, 16'h0000);
		send_command(4'h0, 16'h0000, 16'h1000, 16'h0000);
		send_command(4'h5, 16'h0000, 16'h0000, 16'h0029);
		send_command(4'ha, 16'h4001, 16'h8000, 16'h8000);
		send_command(4'h1, 16'hbfff, 16'h7fff, 16'h8000);
		random_commands(200);
		drain();

		// zero limits and offset act as one LSB; equal ratios
		write_reg(REG_MAX_LINEAR, 15'd0);
		write_reg(REG_MAX_TURN, 15'd0);
		write_reg(REG_OFFSET, 15'd0);
		write_reg(2'd3, 15'h1234);
		send_command(4'h2, 16'h0000, 16'h0010, 16'h0000);
		send_command(4'h3, 16'h0000, 16'h0000, 16'h0000);
		random_commands(150);
		drain();

		write_reg(REG_MAX_LINEAR, 15'h7fff);
		write_reg(REG_MAX_TURN, 15'h7fff);
		write_reg(REG_OFFSET, 15'h7fff);
		random_commands(250);
		drain();

		write_reg(REG_MAX_LINEAR, 15'd2048);
		write_reg(REG_MAX_TURN, 15'd2048);
		write_reg(REG_OFFSET, 15'd4096);
		send_command(4'h4, 16'h0000, 16'd4096, 16'd4096);
		random_commands(250);
		drain();

		for (int p = 0; p < 3; p++) begin
			write_reg(REG_MAX_LINEAR, 15'($urandom_range(1, 32767)));
			write_reg(REG_MAX_TURN, 15'($urandom_range(1, 32767)));
			write_reg(REG_OFFSET, 15'($urandom_range(1, 32767)));
			random_commands(120);
			drain();
		end

		no_gaps = 1;
		write_reg(REG_MAX_LINEAR, RST_MAX_LINEAR);
		write_reg(REG_MAX_TURN, RST_MAX_TURN);
		write_reg(REG_OFFSET, RST_OFFSET);
		random_commands(130);
		drain();

		if (mismatches == 0 && sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
